// ----- rtl/core/ramped_direction_pwm_unit_defines.svh -----
// Assertion helpers shared by the RTL files of the ramped direction PWM unit.
// Every use expects clk_i and rst_ni to be visible in the enclosing module.
`ifndef RAMPED_DIRECTION_PWM_UNIT_DEFINES_SVH
`define RAMPED_DIRECTION_PWM_UNIT_DEFINES_SVH

// Checks that a property holds on every clock edge outside of reset.
`define RDP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle implies a condition in the next cycle.
`define RDP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/rdp_pkg.sv -----
package rdp_pkg;

  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PROD_W     = PERIOD_W + DUTY_W;

  // Reciprocal of 100 scaled by 2^34, rounded up. It gives the exact floor
  // quotient for every product of a 20-bit period and a share of at most 100.
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;

  localparam logic [DUTY_W-1:0]   DUTY_FULL    = 7'd100;
  localparam logic [DUTY_W-1:0]   TARGET_MAX   = 7'd99;
  localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd80;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd80000;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 7'd5;
  localparam logic                DIR_RESET    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

  typedef enum logic {
    OP_RAMP   = 1'b0,
    OP_EXPIRE = 1'b1
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [DUTY_W-1:0] target_speed;
  } in_beat_t;

  typedef struct packed {
    logic                drive_cw;
    logic                drive_ccw;
    logic [PERIOD_W-1:0] next_interval;
    logic [DUTY_W-1:0]   duty_now;
  } out_beat_t;

  // State snapshot after an accepted beat, with the duty share to scale.
  typedef struct packed {
    op_e               op;
    logic [1:0]        pins;
    logic [DUTY_W-1:0] duty;
    logic [DUTY_W-1:0] share;
  } stage_t;

  // Product of period and share, carried with the rest of the result.
  typedef struct packed {
    op_e               op;
    logic [1:0]        pins;
    logic [DUTY_W-1:0] duty;
    logic [PROD_W-1:0] prod;
  } prod_t;

endpackage

// ----- rtl/core/rdp_ctrl.sv -----
`include "ramped_direction_pwm_unit_defines.svh"

module rdp_ctrl
  import rdp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  in_beat_t          in_beat_i,
  output logic              in_ready_o,
  input  logic              direction_i,
  input  logic [STEP_W-1:0] ramp_step_i,
  output logic              stage_valid_o,
  output stage_t            stage_o,
  input  logic              stage_ready_i
);

  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              phase_q, phase_d;
  logic [1:0]        pins_q, pins_d;
  logic              stage_valid_q, stage_valid_d;
  stage_t            stage_q, stage_d;

  logic              accept;
  logic [DUTY_W-1:0] target;
  logic [DUTY_W:0]   up_sum;
  logic [DUTY_W-1:0] down_diff;
  logic [1:0]        pin_sel;
  logic [DUTY_W-1:0] share;

  assign in_ready_o = !stage_valid_q || stage_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign target    = (in_beat_i.target_speed > TARGET_MAX) ? TARGET_MAX
                                                           : in_beat_i.target_speed;
  assign up_sum    = {1'b0, duty_q} + {1'b0, ramp_step_i};
  assign down_diff = duty_q - ramp_step_i;
  assign pin_sel   = direction_i ? 2'b10 : 2'b01;

  always_comb begin
    duty_d  = duty_q;
    phase_d = phase_q;
    pins_d  = pins_q;
    share   = duty_q;
    if (in_beat_i.operation == OP_RAMP) begin
      if (duty_q < target) begin
        duty_d = (up_sum > {1'b0, target}) ? target : up_sum[DUTY_W-1:0];
      end else if (duty_q > target) begin
        // Stepping down never passes the target, nor wraps below zero.
        if ((ramp_step_i >= duty_q) || (down_diff < target)) begin
          duty_d = target;
        end else begin
          duty_d = down_diff;
        end
      end
    end else begin
      phase_d = !phase_q;
      if (!phase_q) begin
        pins_d = pins_q | pin_sel;
        share  = duty_q;
      end else begin
        pins_d = pins_q & ~pin_sel;
        share  = DUTY_FULL - duty_q;
      end
    end
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    stage_d       = stage_q;
    if (in_ready_o) begin
      stage_valid_d = in_valid_i;
      stage_d.op    = in_beat_i.operation;
      stage_d.pins  = pins_d;
      stage_d.duty  = duty_d;
      stage_d.share = share;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q        <= DUTY_RESET;
      phase_q       <= 1'b0;
      pins_q        <= 2'b00;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (accept) begin
        duty_q  <= duty_d;
        phase_q <= phase_d;
        pins_q  <= pins_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

  `RDP_ASSERT(a_duty_range, duty_q <= TARGET_MAX, "duty left the range 0 to 99")
  `RDP_ASSERT_NEXT(a_ramp_keeps_pins, accept && (in_beat_i.operation == OP_RAMP), (pins_q == $past(pins_q)) && (phase_q == $past(phase_q)), "ramp beat changed pins or phase")
  `RDP_ASSERT_NEXT(a_expire_toggles, accept && (in_beat_i.operation == OP_EXPIRE), phase_q != $past(phase_q), "expiry beat did not toggle the phase")
  `RDP_ASSERT(a_share_matches, (stage_valid_q && (stage_q.op == OP_EXPIRE)) |-> ((stage_q.share == stage_q.duty) || (stage_q.share == (DUTY_FULL - stage_q.duty))), "share is neither duty nor its complement")

endmodule

// ----- rtl/core/rdp_interval.sv -----
module rdp_interval
  import rdp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                stage_valid_i,
  input  stage_t              stage_i,
  output logic                stage_ready_o,
  input  logic [PERIOD_W-1:0] period_i,
  output logic                res_valid_o,
  output out_beat_t           res_o,
  input  logic                res_ready_i
);

  localparam int unsigned QMUL_W = PROD_W + RECIP_W;

  logic        prod_valid_q, prod_valid_d;
  prod_t       prod_q, prod_d;
  logic        res_valid_q, res_valid_d;
  out_beat_t   res_q, res_d;
  logic        prod_ready;
  logic [QMUL_W-1:0] qmul;

  assign prod_ready    = !res_valid_q || res_ready_i;
  assign stage_ready_o = !prod_valid_q || prod_ready;

  // First step: period times the duty share.
  always_comb begin
    prod_valid_d = prod_valid_q;
    prod_d       = prod_q;
    if (stage_ready_o) begin
      prod_valid_d = stage_valid_i;
      prod_d.op    = stage_i.op;
      prod_d.pins  = stage_i.pins;
      prod_d.duty  = stage_i.duty;
      prod_d.prod  = {{DUTY_W{1'b0}}, period_i} * {{PERIOD_W{1'b0}}, stage_i.share};
    end
  end

  // Second step: divide by 100 through the scaled reciprocal.
  assign qmul = {{RECIP_W{1'b0}}, prod_q.prod} * {{PROD_W{1'b0}}, RECIP_100};

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (prod_ready) begin
      res_valid_d       = prod_valid_q;
      res_d.drive_cw    = prod_q.pins[0];
      res_d.drive_ccw   = prod_q.pins[1];
      res_d.duty_now    = prod_q.duty;
      res_d.next_interval = (prod_q.op == OP_EXPIRE) ? qmul[RECIP_SHIFT +: PERIOD_W]
                                                     : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/rdp_skid.sv -----
module rdp_skid
  import rdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  out_beat_t in_beat_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output out_beat_t out_beat_o,
  input  logic      out_stall_i
);

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t skid_q, skid_d;

  // The upstream ready comes straight from a register.
  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_valid_q && out_stall_i) begin
      if (in_valid_i && in_ready_o) begin
        skid_valid_d = 1'b1;
        skid_d       = in_beat_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = in_valid_i;
      out_d       = in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ----- rtl/core/ramped_direction_pwm_unit.sv -----
// Ramped direction PWM unit. Each input beat is either a ramp request, which
// moves the duty cycle (in percent) by at most ramp_step toward target_speed
// and never past it, or a timer expiry, which toggles the PWM phase, raises or
// lowers the bridge pin that direction selects, and reports the timer reload
// for the phase just entered (period_cycles * duty / 100 for the high phase,
// period_cycles * (100 - duty) / 100 for the low phase, truncated). Every
// input beat yields exactly one output beat. The unit takes one beat per
// clock cycle while the input is not stalled, and the result of a beat
// passes these steps in order: the duty, phase and pin state update in the
// cycle a beat is accepted, the period multiply and the divide by 100 (a
// reciprocal multiply) each take one registered stage, and an output
// register with a one-entry skid buffer follows. Configuration writes are
// meant for idle periods, when no beat is in flight.
module ramped_direction_pwm_unit
  import rdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic                direction_q;
  logic [PERIOD_W-1:0] period_q;
  logic [STEP_W-1:0]   step_q;

  logic      in_ready;
  logic      stage_valid;
  stage_t    stage;
  logic      stage_ready;
  logic      res_valid;
  out_beat_t res;
  logic      res_ready;

  // Configuration registers. Writes to an index past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_RESET;
      period_q    <= PERIOD_RESET;
      step_q      <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIRECTION: direction_q <= cfg_wdata_i[0];
        CFG_PERIOD:    period_q    <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_STEP:      step_q      <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Duty slewing, phase toggling and pin drive happen at acceptance.
  rdp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_beat_i     (in_beat_i),
    .in_ready_o    (in_ready),
    .direction_i   (direction_q),
    .ramp_step_i   (step_q),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .stage_ready_i (stage_ready)
  );

  // The interval for the phase just entered is scaled over two stages.
  rdp_interval u_interval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .stage_ready_o (stage_ready),
    .period_i      (period_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // The output register and skid entry decouple the two handshakes.
  rdp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_beat_i   (res),
    .in_ready_o  (res_ready),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .out_stall_i (out_stall_i)
  );

  assign in_stall_o = !in_ready;

endmodule
